[hdl/bmprle8_pkg.sv]
// Shared types and constants for the RLE8 bitmap decoder.
`timescale 1ns / 1ps
package bmprle8_pkg;

  // Largest image side that the decoder honours; larger register values are clamped.
  localparam int unsigned MAX_DIM   = 4096;
  localparam int unsigned DIM_W     = 13;
  localparam int unsigned COL_W     = 16;
  localparam int unsigned ADDR_W    = 24;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned MIN_WIDTH = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

  typedef enum logic [2:0] {
    PH_COUNT,
    PH_VALUE,
    PH_ESC,
    PH_DX,
    PH_DY,
    PH_LIT,
    PH_PAD
  } phase_t;

  // Byte classes that matter to the parser: escape codes 0, 1, 2 and the rest.
  typedef enum logic [1:0] {
    BC_ZERO,
    BC_ONE,
    BC_TWO,
    BC_OTHER
  } byte_class_t;

  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } back_state_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              first_byte;
    byte_class_t       cls;
  } item_t;

  // Effective (clamped) image geometry.
  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } geom_t;

endpackage

[hdl/bmprle8_in_if.sv]
// Request channel carrying compressed bytes into the decoder.
`timescale 1ns / 1ps
interface bmprle8_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;

  modport source (output valid, output data_byte, output first_byte, input ready);
  modport sink (input valid, input data_byte, input first_byte, output ready);
endinterface

[hdl/bmprle8_out_if.sv]
// Request channel carrying fill segments and the done marker out of the decoder.
`timescale 1ns / 1ps
interface bmprle8_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] pixel_address;
  logic [7:0]  run_length;
  logic [7:0]  pixel_index;
  logic        out_of_range;
  logic        image_done;
  logic        last_of_run;

  modport source (output valid, output pixel_address, output run_length,
                  output pixel_index, output out_of_range, output image_done,
                  output last_of_run, input ready);
  modport sink (input valid, input pixel_address, input run_length,
                input pixel_index, input out_of_range, input image_done,
                input last_of_run, output ready);
endinterface

[hdl/bmprle8_front.sv]
// Front end: takes input requests, classifies each byte and queues it for the back end.
`timescale 1ns / 1ps
module bmprle8_front (
  input  logic                 clk,
  input  logic                 rst_n,
  bmprle8_in_if.sink           in_req,
  input  logic                 q_pop,
  output logic                 q_valid,
  output bmprle8_pkg::item_t   q_item
);
  import bmprle8_pkg::*;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  item_t              mem_r [QDEPTH];
  logic [QAW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]       count_r, count_nxt;
  logic               push;
  logic               pop;
  item_t              new_item;

  assign in_req.ready = (count_r != (QAW+1)'(QDEPTH));
  assign push         = in_req.valid && in_req.ready;
  assign q_valid      = (count_r != '0);
  assign pop          = q_pop && q_valid;
  assign q_item       = mem_r[rd_ptr_r];

  always_comb begin
    new_item.data_byte  = in_req.data_byte;
    new_item.first_byte = in_req.first_byte;
    case (in_req.data_byte)
      8'd0:    new_item.cls = BC_ZERO;
      8'd1:    new_item.cls = BC_ONE;
      8'd2:    new_item.cls = BC_TWO;
      default: new_item.cls = BC_OTHER;
    endcase
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (QAW+1)'(push) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

[hdl/bmprle8_back.sv]
// Back end: parses queued bytes and emits fill segments and the done marker through a registered output.
`timescale 1ns / 1ps
module bmprle8_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bmprle8_pkg::geom_t   geom,
  input  logic                 q_valid,
  input  bmprle8_pkg::item_t   q_item,
  output logic                 q_pop,
  bmprle8_out_if.source        out_req
);
  import bmprle8_pkg::*;

  back_state_t          state_r, state_nxt;
  phase_t               phase_r, phase_nxt;
  logic [COL_W-1:0]     col_r, col_nxt;
  logic [DIM_W-1:0]     row_r, row_nxt;
  logic [BYTE_W-1:0]    pend_r, pend_nxt;
  logic [BYTE_W-1:0]    lidx_r, lidx_nxt;
  logic                 pad_r, pad_nxt;
  logic                 fin_r, fin_nxt;
  item_t                item_r, item_nxt;
  logic [BYTE_W-1:0]    rem_r, rem_nxt;
  logic [ADDR_W-1:0]    base_r, base_nxt;
  logic                 row_ok_r, row_ok_nxt;

  logic                 ov_r, ov_nxt;
  logic [ADDR_W-1:0]    oaddr_r, oaddr_nxt;
  logic [BYTE_W-1:0]    olen_r, olen_nxt;
  logic [BYTE_W-1:0]    oidx_r, oidx_nxt;
  logic                 ooor_r, ooor_nxt;
  logic                 odone_r, odone_nxt;
  logic                 olast_r, olast_nxt;

  logic                 can_emit;
  logic                 exec_last;
  logic                 fin_eff;
  logic [DIM_W-1:0]     row_eff;
  logic [DIM_W-1:0]     diff;
  logic [2*DIM_W-1:0]   prod;

  // segment datapath
  logic [COL_W-1:0]     w16;
  logic                 col_ge;
  logic [COL_W-1:0]     span;
  logic [BYTE_W-1:0]    seg_len;
  logic [COL_W-1:0]     colsum;
  logic [COL_W-1:0]     seg_col;
  logic [BYTE_W-1:0]    rem_left;
  logic [ADDR_W-1:0]    seg_addr;
  logic                 seg_oor;
  logic [DIM_W:0]       rowsum;
  logic [COL_W:0]       dxsum;
  logic [BYTE_W-1:0]    lidx_inc;

  assign can_emit = !ov_r || out_req.ready;
  assign fin_eff  = q_item.first_byte ? 1'b0 : fin_r;
  assign row_eff  = q_item.first_byte ? '0 : row_r;
  assign diff     = geom.height - DIM_W'(1) - row_eff;
  assign prod     = diff * geom.width;

  assign w16      = COL_W'(geom.width);
  assign col_ge   = (col_r >= w16);
  assign span     = w16 - col_r;
  assign seg_len  = col_ge ? BYTE_W'(1)
                  : ((span > COL_W'(rem_r)) ? rem_r : span[BYTE_W-1:0]);
  assign colsum   = col_r + COL_W'(seg_len);
  assign seg_col  = (col_ge || (colsum >= w16)) ? '0 : colsum;
  assign rem_left = rem_r - seg_len;
  assign seg_addr = row_ok_r ? (base_r + ADDR_W'(col_r)) : '0;
  assign seg_oor  = col_ge || !row_ok_r;
  assign lidx_inc = lidx_r + BYTE_W'(1);

  // rowsum serves both end of line (+1) and the vertical delta
  assign rowsum   = {1'b0, row_r} + ((phase_r == PH_DY) ? (DIM_W+1)'(item_r.data_byte)
                                                        : (DIM_W+1)'(1));
  assign dxsum    = {1'b0, col_r} + (COL_W+1)'(item_r.data_byte);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid && !fin_eff) begin
          state_nxt = BK_EXEC;
        end
      end
      BK_EXEC: begin
        if (can_emit && exec_last) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    q_pop      = 1'b0;
    exec_last  = 1'b1;
    phase_nxt  = phase_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    pend_nxt   = pend_r;
    lidx_nxt   = lidx_r;
    pad_nxt    = pad_r;
    fin_nxt    = fin_r;
    item_nxt   = item_r;
    rem_nxt    = rem_r;
    base_nxt   = base_r;
    row_ok_nxt = row_ok_r;
    ov_nxt     = ov_r && !out_req.ready;
    oaddr_nxt  = oaddr_r;
    olen_nxt   = olen_r;
    oidx_nxt   = oidx_r;
    ooor_nxt   = ooor_r;
    odone_nxt  = odone_r;
    olast_nxt  = olast_r;

    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.first_byte) begin
            phase_nxt = PH_COUNT;
            col_nxt   = '0;
            row_nxt   = '0;
            pend_nxt  = '0;
            lidx_nxt  = '0;
            pad_nxt   = 1'b0;
            fin_nxt   = 1'b0;
          end
          item_nxt   = q_item;
          row_ok_nxt = (row_eff < geom.height);
          base_nxt   = prod[ADDR_W-1:0];
          rem_nxt    = (!q_item.first_byte && phase_r == PH_VALUE) ? pend_r : BYTE_W'(1);
        end
      end
      BK_EXEC: begin
        if (can_emit) begin
          case (phase_r)
            PH_VALUE, PH_LIT: begin
              ov_nxt    = 1'b1;
              oaddr_nxt = seg_addr;
              olen_nxt  = seg_len;
              oidx_nxt  = item_r.data_byte;
              ooor_nxt  = seg_oor;
              odone_nxt = 1'b0;
              olast_nxt = (rem_left == '0);
              col_nxt   = seg_col;
              rem_nxt   = rem_left;
              exec_last = (rem_left == '0);
              if (phase_r == PH_LIT) begin
                lidx_nxt = lidx_inc;
                if (lidx_inc >= pend_r) begin
                  phase_nxt = pad_r ? PH_PAD : PH_COUNT;
                end
              end else if (rem_left == '0) begin
                phase_nxt = PH_COUNT;
              end
            end
            PH_ESC: begin
              unique case (item_r.cls)
                BC_ZERO: begin
                  // end of line
                  col_nxt   = '0;
                  phase_nxt = PH_COUNT;
                  if (rowsum >= {1'b0, geom.height}) begin
                    row_nxt = geom.height;
                    fin_nxt = 1'b1;
                    ov_nxt  = 1'b1;
                  end else begin
                    row_nxt = rowsum[DIM_W-1:0];
                  end
                end
                BC_ONE: begin
                  phase_nxt = PH_COUNT;
                  fin_nxt   = 1'b1;
                  ov_nxt    = 1'b1;
                end
                BC_TWO: begin
                  phase_nxt = PH_DX;
                end
                default: begin
                  pend_nxt  = item_r.data_byte;
                  lidx_nxt  = '0;
                  pad_nxt   = item_r.data_byte[0];
                  phase_nxt = PH_LIT;
                end
              endcase
              if (fin_nxt && !fin_r) begin
                oaddr_nxt = '0;
                olen_nxt  = '0;
                oidx_nxt  = '0;
                ooor_nxt  = 1'b0;
                odone_nxt = 1'b1;
                olast_nxt = 1'b1;
              end
            end
            PH_DX: begin
              col_nxt   = dxsum[COL_W] ? '1 : dxsum[COL_W-1:0];
              phase_nxt = PH_DY;
            end
            PH_DY: begin
              phase_nxt = PH_COUNT;
              if (rowsum >= {1'b0, geom.height}) begin
                row_nxt   = geom.height;
                fin_nxt   = 1'b1;
                ov_nxt    = 1'b1;
                oaddr_nxt = '0;
                olen_nxt  = '0;
                oidx_nxt  = '0;
                ooor_nxt  = 1'b0;
                odone_nxt = 1'b1;
                olast_nxt = 1'b1;
              end else begin
                row_nxt = rowsum[DIM_W-1:0];
              end
            end
            PH_PAD: begin
              phase_nxt = PH_COUNT;
            end
            default: begin
              if (item_r.cls == BC_ZERO) begin
                phase_nxt = PH_ESC;
              end else begin
                pend_nxt  = item_r.data_byte;
                phase_nxt = PH_VALUE;
              end
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      phase_r <= PH_COUNT;
      col_r   <= '0;
      row_r   <= '0;
      pend_r  <= '0;
      lidx_r  <= '0;
      pad_r   <= 1'b0;
      fin_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      pend_r  <= pend_nxt;
      lidx_r  <= lidx_nxt;
      pad_r   <= pad_nxt;
      fin_r   <= fin_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    rem_r    <= rem_nxt;
    base_r   <= base_nxt;
    row_ok_r <= row_ok_nxt;
    oaddr_r  <= oaddr_nxt;
    olen_r   <= olen_nxt;
    oidx_r   <= oidx_nxt;
    ooor_r   <= ooor_nxt;
    odone_r  <= odone_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_req.valid         = ov_r;
  assign out_req.pixel_address = oaddr_r;
  assign out_req.run_length    = olen_r;
  assign out_req.pixel_index   = oidx_r;
  assign out_req.out_of_range  = ooor_r;
  assign out_req.image_done    = odone_r;
  assign out_req.last_of_run   = olast_r;

endmodule

[hdl/bmp_rle8_decoder.sv]
// Top level of the RLE8 bitmap decoder: configuration registers, front end and back end.
// Each byte is accepted into the queue, then popped in the back end's IDLE state (row base
// multiply) and executed in EXEC, one EXEC step per segment of a run, into a registered
// output; the next byte waits for EXEC to end. A byte ignored after done is just popped.
// A 4-entry queue between front and back decouples input stalls from output stalls.
// Reset (synchronous, rst_n low): queue empty, parser expects a count byte, column and
// row zero, width 640, height 480.
`timescale 1ns / 1ps
module bmp_rle8_decoder (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [bmprle8_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bmprle8_pkg::DIM_W-1:0]        cfg_wdata,
  bmprle8_in_if.sink                           in_req,
  bmprle8_out_if.source                        out_req
);
  import bmprle8_pkg::*;

  logic [DIM_W-1:0] width_r, width_nxt;
  logic [DIM_W-1:0] height_r, height_nxt;
  geom_t            geom;
  logic             q_valid;
  logic             q_pop;
  item_t            q_item;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  width_nxt  = cfg_wdata;
        CFG_IMAGE_HEIGHT: height_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  // clamp geometry to the supported range
  always_comb begin
    if (32'(width_r) < MIN_WIDTH) begin
      geom.width = DIM_W'(MIN_WIDTH);
    end else if (32'(width_r) > MAX_DIM) begin
      geom.width = DIM_W'(MAX_DIM);
    end else begin
      geom.width = width_r;
    end
    if (height_r == '0) begin
      geom.height = DIM_W'(1);
    end else if (32'(height_r) > MAX_DIM) begin
      geom.height = DIM_W'(MAX_DIM);
    end else begin
      geom.height = height_r;
    end
  end

  bmprle8_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .q_pop   (q_pop),
    .q_valid (q_valid),
    .q_item  (q_item)
  );

  bmprle8_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .geom    (geom),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .out_req (out_req)
  );

endmodule

[bench/bmp_rle8_decoder_tb.sv]
// Self-checking testbench for the RLE8 bitmap decoder: directed and random byte streams.
`timescale 1ns / 1ps
module bmp_rle8_decoder_tb;
  import bmprle8_pkg::*;

  localparam logic [7:0] ESC_CODE  = 8'h00;  // count byte that opens an escape
  localparam logic [7:0] ESC_EOL   = 8'h00;
  localparam logic [7:0] ESC_EOB   = 8'h01;
  localparam logic [7:0] ESC_DELTA = 8'h02;
  localparam int         MAX_GAP   = 17;
  localparam int         HOLD_CYC  = 400;
  localparam int         SETTLE    = 30;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [7:0]        len;
    logic [7:0]        pix;
    logic              oor;
    logic              done;
    logic              last;
  } seg_t;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
  } stim_t;

  // Tracks decoder state and holds the segments still owed by the block.
  class rle8_scoreboard;
    logic [DIM_W-1:0] width_reg  = WIDTH_RESET;
    logic [DIM_W-1:0] height_reg = HEIGHT_RESET;
    phase_t      phase     = PH_COUNT;
    int unsigned col       = 0;
    int unsigned row       = 0;
    int unsigned run_count = 0;
    int unsigned lit_done  = 0;
    bit          odd_pad   = 1'b0;
    bit          finished  = 1'b0;
    seg_t        expected_q[$];
    int          fails     = 0;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] v);
      if (idx == CFG_IMAGE_WIDTH) width_reg = v;
      else height_reg = v;
    endfunction

    function int unsigned eff_height();
      if (height_reg < 1) return 1;
      if (height_reg > MAX_DIM) return MAX_DIM;
      return height_reg;
    endfunction

    function void end_image();
      seg_t s;
      s = '0;
      s.done = 1'b1;
      finished = 1'b1;
      phase = PH_COUNT;
      expected_q.push_back(s);
    endfunction

    // Splits a run into segments wherever the column wraps.
    function void fill(int unsigned count, logic [7:0] pix);
      int unsigned w, h, remaining, start, len, addr;
      bit oor;
      seg_t s;
      w = width_reg < MIN_WIDTH ? MIN_WIDTH : (width_reg > MAX_DIM ? MAX_DIM : width_reg);
      h = eff_height();
      remaining = count;
      while (remaining > 0) begin
        start = col;
        oor = 1'b0;
        addr = 0;
        if (col >= w) begin
          len = 1;
          oor = 1'b1;
          col = 0;
        end else begin
          len = w - col;
          if (len > remaining) len = remaining;
          col += len;
          if (col >= w) col = 0;
        end
        if (row < h) addr = start + (h - 1 - row) * w;
        else oor = 1'b1;
        s.addr = addr[ADDR_W-1:0];
        s.len  = len[7:0];
        s.pix  = pix;
        s.oor  = oor;
        s.done = 1'b0;
        s.last = 1'b0;
        expected_q.push_back(s);
        remaining -= len;
      end
    endfunction

    function void note_request(logic [7:0] b, logic f);
      int unsigned h;
      int prev_size;
      h = eff_height();
      prev_size = expected_q.size();
      if (f) begin
        phase = PH_COUNT;
        col = 0;
        row = 0;
        run_count = 0;
        lit_done = 0;
        odd_pad = 1'b0;
        finished = 1'b0;
      end
      if (finished) return;
      case (phase)
        PH_VALUE: begin
          fill(run_count, b);
          phase = PH_COUNT;
        end
        PH_ESC: begin
          if (b == ESC_EOL) begin
            row++;
            col = 0;
            phase = PH_COUNT;
            if (row >= h) begin
              row = h;
              end_image();
            end
          end else if (b == ESC_EOB) begin
            end_image();
          end else if (b == ESC_DELTA) begin
            phase = PH_DX;
          end else begin
            run_count = b;
            lit_done = 0;
            odd_pad = b[0];
            phase = PH_LIT;
          end
        end
        PH_DX: begin
          col += b;
          if (col > 16'hFFFF) col = 16'hFFFF;
          phase = PH_DY;
        end
        PH_DY: begin
          row += b;
          phase = PH_COUNT;
          if (row >= h) begin
            row = h;
            end_image();
          end
        end
        PH_LIT: begin
          fill(1, b);
          lit_done = (lit_done + 1) & 8'hFF;
          if (lit_done >= run_count) phase = odd_pad ? PH_PAD : PH_COUNT;
        end
        PH_PAD: phase = PH_COUNT;
        default: begin
          if (b == ESC_CODE) begin
            phase = PH_ESC;
          end else begin
            run_count = b;
            phase = PH_VALUE;
          end
        end
      endcase
      if (expected_q.size() > prev_size) expected_q[expected_q.size()-1].last = 1'b1;
    endfunction

    function void check_result(seg_t got);
      seg_t want;
      if (expected_q.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("%0t: unexpected result addr=%h len=%0d idx=%h oor=%b done=%b last=%b",
                   $realtime, got.addr, got.len, got.pix, got.oor, got.done, got.last);
        return;
      end
      want = expected_q.pop_front();
      if (got.addr !== want.addr || got.len !== want.len || got.pix !== want.pix ||
          got.oor !== want.oor || got.done !== want.done || got.last !== want.last) begin
        fails++;
        if (fails <= 10) begin
          $display("%0t: mismatch expected addr=%h len=%0d idx=%h oor=%b done=%b last=%b",
                   $realtime, want.addr, want.len, want.pix, want.oor, want.done, want.last);
          $display("%0t:          actual   addr=%h len=%0d idx=%h oor=%b done=%b last=%b",
                   $realtime, got.addr, got.len, got.pix, got.oor, got.done, got.last);
        end
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_wdata;

  bmprle8_in_if  in_ch ();
  bmprle8_out_if out_ch ();

  bmp_rle8_decoder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_req    (in_ch),
    .out_req   (out_ch)
  );

  always #10 clk = ~clk;

  rle8_scoreboard sb;
  stim_t          stim_q[$];
  bit             restart_next;
  bit             in_idle;
  bit             out_idle;
  bit             hold_off;
  int             bytes_sent;

  function automatic void add_byte(logic [7:0] b);
    stim_t s;
    s.data = b;
    s.first = restart_next;
    restart_next = 1'b0;
    stim_q.push_back(s);
  endfunction

  function automatic int run_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(1, 12);
    if (r < 9) return $urandom_range(13, 64);
    return $urandom_range(65, 255);
  endfunction

  function automatic int lit_len();
    if ($urandom_range(0, 39) == 0) return $urandom_range(128, 255);
    if ($urandom_range(0, 7) == 0) return $urandom_range(11, 60);
    return $urandom_range(3, 10);
  endfunction

  function automatic logic [DIM_W-1:0] pick_width();
    case ($urandom_range(0, 7))
      0: return 13'd8;
      1: return 13'd4096;
      2: return 13'd0;
      3: return 13'd8191;
      4: return 13'd640;
      7: return 13'($urandom_range(41, 1000));
      default: return 13'($urandom_range(8, 40));
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] pick_height();
    case ($urandom_range(0, 7))
      0: return 13'd1;
      1: return 13'd4096;
      2: return 13'd0;
      3: return 13'd8191;
      7: return 13'($urandom_range(13, 600));
      default: return 13'($urandom_range(2, 12));
    endcase
  endfunction

  // Mostly well-formed commands with random content; a little noise to break sequences.
  function automatic void build_image(bit restart, int target);
    int sel, n;
    restart_next = restart;
    while (stim_q.size() < target) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        add_byte(8'(run_len()));
        add_byte(8'($urandom_range(0, 255)));
      end else if (sel < 68) begin
        n = lit_len();
        add_byte(ESC_CODE);
        add_byte(8'(n));
        repeat (n) add_byte(8'($urandom_range(0, 255)));
        if (n % 2 == 1) add_byte(8'($urandom_range(0, 255)));
      end else if (sel < 78) begin
        add_byte(ESC_CODE);
        add_byte(ESC_EOL);
      end else if (sel < 90) begin
        add_byte(ESC_CODE);
        add_byte(ESC_DELTA);
        add_byte(8'($urandom_range(0, 5) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 12)));
        add_byte(8'($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0));
      end else if (sel < 96) begin
        restart_next = ($urandom_range(0, 3) == 0);
        add_byte(8'($urandom_range(0, 255)));
      end else begin
        add_byte(ESC_CODE);
        add_byte(ESC_EOB);
        repeat ($urandom_range(0, 2)) add_byte(8'($urandom_range(0, 255)));
        break;
      end
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic f);
    int gap;
    gap = in_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.first_byte <= f;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(b, f);
    bytes_sent++;
  endtask

  task automatic drive_stream();
    stim_t s;
    while (stim_q.size() != 0) begin
      s = stim_q.pop_front();
      send_byte(s.data, s.first);
    end
    in_ch.valid <= 1'b0;
  endtask

  // Writes back to back; the enable is dropped once, after the last write.
  task automatic configure(input bit set_w, input logic [DIM_W-1:0] w,
                           input bit set_h, input logic [DIM_W-1:0] h);
    if (set_w) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IMAGE_WIDTH;
      cfg_wdata <= w;
      @(posedge clk);
      sb.write_reg(CFG_IMAGE_WIDTH, w);
    end
    if (set_h) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IMAGE_HEIGHT;
      cfg_wdata <= h;
      @(posedge clk);
      sb.write_reg(CFG_IMAGE_HEIGHT, h);
    end
    cfg_we <= 1'b0;
  endtask

  // Bytes that yield no segment may still sit in the input queue when the last one lands.
  task automatic wait_idle();
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic collect_results();
    int   stall;
    seg_t got;
    forever begin
      if (hold_off) begin
        hold_off = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk);
      end
      stall = out_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got.addr = out_ch.pixel_address;
      got.len  = out_ch.run_length;
      got.pix  = out_ch.pixel_index;
      got.oor  = out_ch.out_of_range;
      got.done = out_ch.image_done;
      got.last = out_ch.last_of_run;
      sb.check_result(got);
    end
  endtask

  initial begin
    #150ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int phase_no;
    int rand_start;
    bit set_w, set_h;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_IMAGE_WIDTH;
    cfg_wdata        <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.data_byte  <= '0;
    in_ch.first_byte <= 1'b0;
    out_ch.ready     <= 1'b0;
    sb = new;
    in_idle = 1'b1;
    out_idle = 1'b1;
    hold_off = 1'b0;
    bytes_sent = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    fork
      collect_results();
    join_none

    // reset geometry, 640 x 480
    restart_next = 1'b1;
    add_byte(8'h03);
    add_byte(8'h44);
    drive_stream();
    wait_idle();

    // narrowest image: runs that wrap many times, odd literal with pad, delta past the
    // row end, end of line, delta past the last row, ignored byte, end of bitmap
    configure(1'b1, 13'd8, 1'b1, 13'd3);
    restart_next = 1'b1;
    add_byte(8'h05);      add_byte(8'hAA);
    add_byte(8'hFF);      add_byte(8'h00);
    add_byte(ESC_CODE);   add_byte(8'h03);
    add_byte(8'h01);      add_byte(8'h80);   add_byte(8'h7F);   add_byte(8'h55);
    add_byte(ESC_CODE);   add_byte(ESC_DELTA); add_byte(8'h0A); add_byte(8'h00);
    add_byte(8'h02);      add_byte(8'h33);
    add_byte(ESC_CODE);   add_byte(ESC_EOL);
    add_byte(ESC_CODE);   add_byte(ESC_DELTA); add_byte(8'h00); add_byte(8'h05);
    add_byte(8'h01);
    restart_next = 1'b1;
    add_byte(ESC_CODE);   add_byte(ESC_EOB);
    drive_stream();
    wait_idle();

    // clamped extremes, then height lowered below the current row mid-stream
    configure(1'b1, 13'd8191, 1'b1, 13'd8191);
    restart_next = 1'b1;
    repeat (3) begin
      add_byte(ESC_CODE);
      add_byte(ESC_EOL);
    end
    drive_stream();
    wait_idle();
    configure(1'b0, '0, 1'b1, 13'd0);
    add_byte(8'h04);      add_byte(8'h11);
    add_byte(ESC_CODE);   add_byte(ESC_EOL);
    drive_stream();
    wait_idle();

    // deltas that carry the column far past the row end
    configure(1'b1, 13'd0, 1'b0, '0);
    in_idle = 1'b0;
    out_idle = 1'b0;
    restart_next = 1'b1;
    repeat (4) begin
      add_byte(ESC_CODE);
      add_byte(ESC_DELTA);
      add_byte(8'hFF);
      add_byte(8'h00);
    end
    add_byte(8'h02);      add_byte(8'h5A);
    add_byte(ESC_CODE);   add_byte(ESC_EOB);
    drive_stream();
    wait_idle();

    rand_start = bytes_sent;
    phase_no = 0;
    while (bytes_sent - rand_start < 330) begin
      set_w = $urandom_range(0, 1);
      set_h = $urandom_range(0, 1);
      if (set_w || set_h) configure(set_w, pick_width(), set_h, pick_height());
      in_idle = ($urandom_range(0, 3) != 0);
      out_idle = ($urandom_range(0, 3) != 0);
      if (phase_no == 2) begin
        hold_off = 1'b1;
        in_idle = 1'b0;
      end
      build_image(sb.finished || $urandom_range(0, 4) != 0, $urandom_range(40, 80));
      drive_stream();
      wait_idle();
      phase_no++;
    end

    if (sb.expected_q.size() != 0) begin
      $display("%0d expected results never arrived", sb.expected_q.size());
      sb.fails++;
    end
    if (sb.fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
